[rtl/elementwise_safe_divide_macros.svh]
// assertion macros for the elementwise safe divide block
// expects clk and rst in the scope of the module that uses them
`ifndef ELEMENTWISE_SAFE_DIVIDE_MACROS_SVH
`define ELEMENTWISE_SAFE_DIVIDE_MACROS_SVH

// same-cycle implication
`define ESD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esd assertion failed");

// next-cycle implication
`define ESD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esd assertion failed");

`endif

[rtl/esd_pkg.sv]
// shared types, codes and helpers for the elementwise safe divide block
// no dependencies
package esd_pkg;

  localparam logic [3:0] TYPE_F32 = 4'd1;
  localparam logic [3:0] TYPE_I32 = 4'd6;
  localparam logic [3:0] TYPE_I64 = 4'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  localparam logic [1:0] MODE_F32  = 2'd0;
  localparam logic [1:0] MODE_I32  = 2'd1;
  localparam logic [1:0] MODE_I64  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int DIV_W      = 64;
  localparam int DIV_STAGES = 64;
  localparam int F_SHIFT    = 26;

  // 1e-6 in single precision, and the default quiet nan
  localparam logic [31:0] F32_EPS  = 32'h358637BD;
  localparam logic [31:0] F32_QNAN = 32'hFFC00000;
  localparam logic [31:0] F32_QBIT = 32'h00400000;

  localparam logic [3:0] REG_ELEMENT_TYPE = 4'd0;

  typedef struct packed {
    logic signed [63:0] dividend;
    logic signed [63:0] divisor;
  } src_t;

  typedef struct packed {
    logic signed [63:0] quotient;
    logic [1:0]         status;
  } dst_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               neg;
    logic [1:0]         status;
    logic               special;
    logic [31:0]        fixed;
    logic signed [10:0] exp;
  } meta_t;

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] cnt;
    cnt = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) cnt = 5'(23 - i);
    end
    return cnt;
  endfunction

endpackage

[rtl/elementwise_safe_divide.sv]
// Elementwise safe divide: one dividend/divisor pair in, one quotient and
// status out, per item. Fully pipelined: one item per cycle unless the output
// skid entry is full, through an unpack stage, the 64-stage radix-2 divider,
// a round/pack stage and the output register.
// element_type (APB address 0) picks float32, int32 or int64.
module elementwise_safe_divide (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  esd_pkg::src_t        src_item,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output esd_pkg::dst_t        dst_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import esd_pkg::*;

  logic [3:0] element_type;
  logic       en;
  logic       p_valid, d_valid, o_valid;
  logic [63:0] p_n, p_d, d_q, d_r;
  meta_t      p_meta, d_meta;
  dst_t       o_item;

  assign pready    = 1'b1;
  assign prdata    = {28'd0, element_type};
  assign src_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= TYPE_F32;
    end else if (psel && penable && pwrite && ({2'b0, paddr} == REG_ELEMENT_TYPE)) begin
      element_type <= pwdata[3:0];
    end
  end

  esd_prep u_prep (
    .clk, .rst, .en, .element_type,
    .in_valid(src_valid), .in_item(src_item),
    .valid(p_valid), .n(p_n), .d(p_d), .meta(p_meta)
  );

  esd_div u_div (
    .clk, .rst, .en,
    .in_valid(p_valid), .in_n(p_n), .in_d(p_d), .in_meta(p_meta),
    .out_valid(d_valid), .out_q(d_q), .out_r(d_r), .out_meta(d_meta)
  );

  esd_post u_post (
    .clk, .rst, .en,
    .in_valid(d_valid), .q(d_q), .r(d_r), .meta(d_meta),
    .valid(o_valid), .item(o_item)
  );

  esd_out u_out (
    .clk, .rst, .pvalid(o_valid), .pitem(o_item), .en,
    .dst_valid, .dst_stall, .dst_item
  );

endmodule

[rtl/esd_prep.sv]
// input stage: decodes the type, clamps small float divisors, unpacks
// and normalizes float operands, takes integer magnitudes; uses esd_pkg
module esd_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [3:0]           element_type,
  input  logic                 in_valid,
  input  esd_pkg::src_t        in_item,
  output logic                 valid,
  output logic [63:0]          n,
  output logic [63:0]          d,
  output esd_pkg::meta_t       meta
);
  import esd_pkg::*;

  logic [31:0] fa, fb0, fb;
  logic        clamp;
  logic [7:0]  ea, eb;
  logic [22:0] xa, xb;
  logic        a_nan, a_inf, a_zero, b_nan, b_inf;
  logic        f_sign;
  logic [23:0] ma, mb, mna, mnb;
  logic [4:0]  lza, lzb;
  logic signed [10:0] ea_eff, eb_eff;
  logic [63:0] sa, sb, abs_a, abs_b;
  logic [63:0] n_next, d_next;
  meta_t       meta_next;

  always_comb begin
    fa     = in_item.dividend[31:0];
    fb0    = in_item.divisor[31:0];
    clamp  = fb0[30:0] < F32_EPS[30:0];
    fb     = clamp ? F32_EPS : fb0;
    ea     = fa[30:23];
    xa     = fa[22:0];
    eb     = fb[30:23];
    xb     = fb[22:0];
    a_nan  = (&ea) && (|xa);
    a_inf  = (&ea) && !(|xa);
    a_zero = (ea == 8'd0) && (xa == 23'd0);
    b_nan  = (&eb) && (|xb);
    b_inf  = (&eb) && !(|xb);
    f_sign = fa[31] ^ fb[31];
    ma     = {|ea, xa};
    mb     = {|eb, xb};
    lza    = lzc24(ma);
    lzb    = lzc24(mb);
    mna    = ma << lza;
    mnb    = mb << lzb;
    ea_eff = ((ea == 8'd0) ? 11'sd1 : $signed({3'b0, ea})) - $signed({6'b0, lza});
    eb_eff = ((eb == 8'd0) ? 11'sd1 : $signed({3'b0, eb})) - $signed({6'b0, lzb});

    if (element_type == TYPE_I32) begin
      sa = {{32{in_item.dividend[31]}}, in_item.dividend[31:0]};
      sb = {{32{in_item.divisor[31]}}, in_item.divisor[31:0]};
    end else begin
      sa = in_item.dividend;
      sb = in_item.divisor;
    end
    abs_a = sa[63] ? (64'd0 - sa) : sa;
    abs_b = sb[63] ? (64'd0 - sb) : sb;

    meta_next         = '0;
    n_next            = abs_a;
    d_next            = abs_b;
    case (element_type)
      TYPE_F32: begin
        meta_next.mode   = MODE_F32;
        meta_next.neg    = f_sign;
        meta_next.status = clamp ? ST_CLAMP : ST_OK;
        meta_next.exp    = ea_eff - eb_eff + 11'sd127;
        n_next           = 64'(mna) << F_SHIFT;
        d_next           = 64'(mnb);
        meta_next.special = a_nan || b_nan || a_inf || b_inf || a_zero;
        if (a_nan)               meta_next.fixed = fa | F32_QBIT;
        else if (b_nan)          meta_next.fixed = fb | F32_QBIT;
        else if (a_inf && b_inf) meta_next.fixed = F32_QNAN;
        else if (a_inf)          meta_next.fixed = {f_sign, 8'hFF, 23'd0};
        else                     meta_next.fixed = {f_sign, 31'd0};
      end
      TYPE_I32, TYPE_I64: begin
        meta_next.mode    = (element_type == TYPE_I32) ? MODE_I32 : MODE_I64;
        meta_next.neg     = sa[63] ^ sb[63];
        meta_next.special = (sb == 64'd0);
        meta_next.status  = (sb == 64'd0) ? ST_ZERO : ST_OK;
      end
      default: begin
        meta_next.mode    = MODE_NONE;
        meta_next.special = 1'b1;
        meta_next.status  = ST_UNSUP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n    <= n_next;
      d    <= d_next;
      meta <= meta_next;
    end
  end

endmodule

[rtl/esd_div.sv]
// radix-2 restoring divider, one quotient bit per register stage
// unsigned DIV_W-bit operands, quotient and remainder out; uses esd_pkg
module esd_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          in_n,
  input  logic [63:0]          in_d,
  input  esd_pkg::meta_t       in_meta,
  output logic                 out_valid,
  output logic [63:0]          out_q,
  output logic [63:0]          out_r,
  output esd_pkg::meta_t       out_meta
);
  import esd_pkg::*;

  logic              vld [DIV_STAGES+1];
  logic [DIV_W-1:0]  rr  [DIV_STAGES+1];
  logic [DIV_W-1:0]  nn  [DIV_STAGES+1];
  logic [DIV_W-1:0]  dd  [DIV_STAGES+1];
  meta_t             mm  [DIV_STAGES+1];

  assign vld[0] = in_valid;
  assign rr[0]  = '0;
  assign nn[0]  = in_n;
  assign dd[0]  = in_d;
  assign mm[0]  = in_meta;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DIV_W:0]   t;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] r_next;
    logic [DIV_W-1:0] n_next;

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
      t      = {rr[g], nn[g][DIV_W-1]};
      diff   = t - {1'b0, dd[g]};
      ge     = t >= {1'b0, dd[g]};
      r_next = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
      n_next = {nn[g][DIV_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[g+1] <= r_next;
        nn[g+1] <= n_next;
        dd[g+1] <= dd[g];
        mm[g+1] <= mm[g];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_q     = nn[DIV_STAGES];
  assign out_r     = rr[DIV_STAGES];
  assign out_meta  = mm[DIV_STAGES];

endmodule

[rtl/esd_post.sv]
// result stage: float normalize, round to nearest even and pack,
// integer sign fix and narrowing; uses esd_pkg
module esd_post (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          q,
  input  logic [63:0]          r,
  input  esd_pkg::meta_t       meta,
  output logic                 valid,
  output esd_pkg::dst_t        item
);
  import esd_pkg::*;

  logic [26:0]        sig;
  logic signed [10:0] e;
  logic signed [10:0] s;
  logic [4:0]         sc;
  logic [7:0]         eb;
  logic [27:0]        w;
  logic [59:0]        wide;
  logic [27:0]        kept;
  logic [23:0]        mant;
  logic               g, stk, rnd;
  logic [30:0]        body;
  logic [31:0]        fbits;
  logic [63:0]        qs;
  dst_t               item_next;

  always_comb begin
    sig  = q[26] ? q[26:0] : {q[25:0], 1'b0};
    e    = q[26] ? meta.exp : meta.exp - 11'sd1;
    s    = 11'sd1 - e;
    if (e < 11'sd1) begin
      sc = (s > 11'sd31) ? 5'd31 : s[4:0];
      eb = 8'd0;
    end else begin
      sc = 5'd0;
      eb = e[7:0];
    end
    // denormal shift keeps a sticky of everything pushed out
    w    = {sig, |r};
    wide = {w, 32'd0} >> sc;
    kept = wide[59:32];
    mant = kept[27:4];
    g    = kept[3];
    stk  = (|kept[2:0]) | (|wide[31:0]);
    rnd  = g && (stk || mant[0]);
    body = {eb, mant[22:0]} + 31'(rnd);
    if (meta.special) fbits = meta.fixed;
    else if (e >= 11'sd255) fbits = {meta.neg, 8'hFF, 23'd0};
    else fbits = {meta.neg, body};

    qs = meta.neg ? (64'd0 - q) : q;

    item_next.status = meta.status;
    case (meta.mode)
      MODE_F32: item_next.quotient = {{32{fbits[31]}}, fbits};
      MODE_I32: item_next.quotient = meta.special ? 64'sd0 : {{32{qs[31]}}, qs[31:0]};
      MODE_I64: item_next.quotient = meta.special ? 64'sd0 : qs;
      default:  item_next.quotient = 64'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule

[rtl/esd_out.sv]
// output register with one skid entry; freezes the pipeline only when
// the skid entry is full; uses esd_pkg and the assertion macros
`include "elementwise_safe_divide_macros.svh"
module esd_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pvalid,
  input  esd_pkg::dst_t        pitem,
  output logic                 en,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output esd_pkg::dst_t        dst_item
);
  import esd_pkg::*;

  logic skid_valid;
  dst_t skid_item;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!dst_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (pvalid) begin
      if (dst_valid && dst_stall) begin
        skid_valid <= 1'b1;
      end else begin
        dst_valid <= 1'b1;
      end
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!dst_stall) dst_item <= skid_item;
    end else if (pvalid) begin
      if (dst_valid && dst_stall) skid_item <= pitem;
      else dst_item <= pitem;
    end
  end

  `ESD_ASSERT_NOW(a_skid_behind_out, skid_valid, dst_valid)
  `ESD_ASSERT_NEXT(a_skid_drains, skid_valid && !dst_stall, dst_valid && !skid_valid)
  `ESD_ASSERT_NEXT(a_skid_catches, pvalid && en && dst_valid && dst_stall, skid_valid)

endmodule
